// ===== rtl/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 16;

   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   typedef enum logic [1:0] {
      ACT_APPEND  = 2'd0,
      ACT_INSERT  = 2'd1,
      ACT_DELETE  = 2'd2,
      ACT_REVERSE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_FULL  = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_ROTATE = 2'd3
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type            mode;
      logic [IDX_W-1:0]         mark;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] value;
      logic signed [POS_W-1:0]  position;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] element;
      logic                     list_empty;
      logic [1:0]               error_code;
      logic                     last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/ple_cell.sv =====
`default_nettype none

module ple_cell (
   input  wire logic                             clock,
   input  wire logic [ple_pkg::IDX_W-1:0]        idx,
   input  wire ple_pkg::cell_ctrl_type           ctrl,
   input  wire logic signed [ple_pkg::DATA_W-1:0] left_data,
   input  wire logic signed [ple_pkg::DATA_W-1:0] right_data,
   input  wire logic signed [ple_pkg::DATA_W-1:0] head_data,
   output logic signed [ple_pkg::DATA_W-1:0]      data
);

   logic signed [ple_pkg::DATA_W-1:0] data_ff;
   logic signed [ple_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctrl.mode)
         ple_pkg::CELL_HOLD: begin
            data_in = data_ff;
         end
         ple_pkg::CELL_INSERT: begin
            // open a gap at the mark: cells above take from below
            if (idx > ctrl.mark) begin
               data_in = left_data;
            end else if (idx == ctrl.mark) begin
               data_in = ctrl.value;
            end
         end
         ple_pkg::CELL_DELETE: begin
            if (idx >= ctrl.mark) begin
               data_in = right_data;
            end
         end
         ple_pkg::CELL_ROTATE: begin
            // move the head item down to the mark, close up below it
            if (idx < ctrl.mark) begin
               data_in = right_data;
            end else if (idx == ctrl.mark) begin
               data_in = head_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== rtl/positional_list_engine.sv =====
`default_nettype none

// Channel   Ports                    Handshake
// request   start, busy, req_item    taken when start is high and busy is low
// response  rsp_strobe, rsp_item     one item per cycle while listing, no back pressure
//
// A command first updates the cell row; a reverse then moves the head item
// down to each mark in turn, from len-1 down to 1; then the row rotates to
// list the contents. Each rotation step passes one item through the cell row.
// Reset clears the length and the sequencer; cell contents are not cleared.
// Responses cannot be stalled; the last one leaves in the cycle start can be taken again.

module positional_list_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire ple_pkg::req_item_type req_item,
   output logic                       rsp_strobe,
   output ple_pkg::rsp_item_type      rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REVERSE,
      ST_LIST
   } state_type;

   state_type                      state_ff;
   logic [ple_pkg::LEN_W-1:0]      len_ff;
   logic [ple_pkg::LEN_W-1:0]      len_in;
   logic [ple_pkg::IDX_W-1:0]      cnt_ff;
   ple_pkg::error_type             err_ff;
   ple_pkg::error_type             err_in;
   logic                           rsp_strobe_ff;
   ple_pkg::rsp_item_type          rsp_item_ff;
   logic                           go_reverse;

   ple_pkg::cell_ctrl_type         ctrl;
   logic signed [ple_pkg::DATA_W-1:0] cell_data [ple_pkg::CAPACITY];

   logic                           accept;
   logic signed [ple_pkg::POS_W-1:0] len_wide;
   logic signed [ple_pkg::POS_W-1:0] pos_m1;
   logic [ple_pkg::LEN_W-1:0]      len_m1;
   logic                           full;
   logic                           at_last;

   assign accept   = start && (state_ff == ST_IDLE);
   assign len_wide = $signed({{(ple_pkg::POS_W - ple_pkg::LEN_W){1'b0}}, len_ff});
   assign pos_m1   = req_item.position - ple_pkg::POS_W'(1);
   assign len_m1   = len_ff - ple_pkg::LEN_W'(1);
   assign full     = (len_ff >= ple_pkg::CAP_LEN);
   assign at_last  = (cnt_ff == len_m1[ple_pkg::IDX_W-1:0]);

   always_comb begin
      ctrl.mode  = ple_pkg::CELL_HOLD;
      ctrl.mark  = '0;
      ctrl.value = req_item.value;
      len_in     = len_ff;
      err_in     = ple_pkg::ERR_NONE;
      go_reverse = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (ple_pkg::action_type'(req_item.action))
                  ple_pkg::ACT_APPEND: begin
                     if (full) begin
                        err_in = ple_pkg::ERR_FULL;
                     end else begin
                        ctrl.mode = ple_pkg::CELL_INSERT;
                        ctrl.mark = len_ff[ple_pkg::IDX_W-1:0];
                        len_in    = len_ff + ple_pkg::LEN_W'(1);
                     end
                  end
                  ple_pkg::ACT_INSERT: begin
                     priority if (req_item.position < 0 || req_item.position > len_wide) begin
                        err_in = ple_pkg::ERR_RANGE;
                     end else if (full) begin
                        err_in = ple_pkg::ERR_FULL;
                     end else begin
                        ctrl.mode = ple_pkg::CELL_INSERT;
                        ctrl.mark = req_item.position[ple_pkg::IDX_W-1:0];
                        len_in    = len_ff + ple_pkg::LEN_W'(1);
                     end
                  end
                  ple_pkg::ACT_DELETE: begin
                     if (req_item.position < 1 || req_item.position > len_wide) begin
                        err_in = ple_pkg::ERR_RANGE;
                     end else begin
                        ctrl.mode = ple_pkg::CELL_DELETE;
                        ctrl.mark = pos_m1[ple_pkg::IDX_W-1:0];
                        len_in    = len_m1;
                     end
                  end
                  ple_pkg::ACT_REVERSE: begin
                     go_reverse = (len_ff > ple_pkg::LEN_W'(1));
                  end
                  default: begin
                     ctrl.mode = ple_pkg::CELL_HOLD;
                  end
               endcase
            end
         end
         ST_REVERSE: begin
            ctrl.mode = ple_pkg::CELL_ROTATE;
            ctrl.mark = cnt_ff;
         end
         ST_LIST: begin
            if (len_ff != '0) begin
               ctrl.mode = ple_pkg::CELL_ROTATE;
               ctrl.mark = len_m1[ple_pkg::IDX_W-1:0];
            end
         end
         default: begin
            ctrl.mode = ple_pkg::CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         cnt_ff        <= '0;
         err_ff        <= ple_pkg::ERR_NONE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  len_ff <= len_in;
                  err_ff <= err_in;
                  if (go_reverse) begin
                     cnt_ff   <= len_m1[ple_pkg::IDX_W-1:0];
                     state_ff <= ST_REVERSE;
                  end else begin
                     cnt_ff   <= '0;
                     state_ff <= ST_LIST;
                  end
               end
            end
            ST_REVERSE: begin
               if (cnt_ff == ple_pkg::IDX_W'(1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_LIST;
               end else begin
                  cnt_ff <= cnt_ff - ple_pkg::IDX_W'(1);
               end
            end
            ST_LIST: begin
               rsp_strobe_ff          <= 1'b1;
               rsp_item_ff.error_code <= err_ff;
               if (len_ff == '0) begin
                  rsp_item_ff.element    <= '0;
                  rsp_item_ff.list_empty <= 1'b1;
                  rsp_item_ff.last       <= 1'b1;
                  state_ff               <= ST_IDLE;
               end else begin
                  // emit the head while the row rotates it to the tail
                  rsp_item_ff.element    <= cell_data[0];
                  rsp_item_ff.list_empty <= 1'b0;
                  rsp_item_ff.last       <= at_last;
                  if (at_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + ple_pkg::IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   for (genvar g = 0; g < ple_pkg::CAPACITY; g++) begin : g_cell
      logic signed [ple_pkg::DATA_W-1:0] left_data;
      logic signed [ple_pkg::DATA_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = ctrl.value;
      end else begin : g_mid_left
         assign left_data = cell_data[g-1];
      end

      if (g == ple_pkg::CAPACITY - 1) begin : g_end
         assign right_data = '0;
      end else begin : g_mid_right
         assign right_data = cell_data[g+1];
      end

      ple_cell u_cell (
         .clock      (clock),
         .idx        (ple_pkg::IDX_W'(g)),
         .ctrl       (ctrl),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data       (cell_data[g])
      );
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= ple_pkg::CAP_LEN)
      else $error("list length beyond capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command taken but sequencer not busy");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.list_empty) |-> rsp_item.last)
      else $error("empty listing not marked last");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last) |=> !rsp_strobe)
      else $error("item emitted right after end of listing");

   a_list_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |-> (state_ff == ST_LIST))
      else $error("listing stopped before last item");

endmodule

`default_nettype wire

// ===== test/tb_positional_list_engine.sv =====
`default_nettype none

module tb_positional_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 250;
   localparam int TAIL_CYCLES    = 2 * ple_pkg::CAPACITY + 8;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      ple_pkg::req_item_type item;
      bit                    drain_first;
   } cmd_entry_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   ple_pkg::req_item_type req_item = '0;
   logic                  rsp_strobe;
   ple_pkg::rsp_item_type rsp_item;

   cmd_entry_type                     cmd_queue[$];
   ple_pkg::rsp_item_type             listing_queue[$];
   logic signed [ple_pkg::DATA_W-1:0] shadow_list[$];

   int   gen_len = 0;
   int   accepted_count = 0;
   int   result_count = 0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;
   logic item_taken = 1'b0;

   positional_list_engine dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH result %0d: %s got %0h expected %0h", result_count, what, got, want);
      mismatch_count++;
   endtask

   // Track only the length so that positions can be aimed at the live list.
   task automatic queue_cmd(logic [1:0] act, logic [31:0] val, logic [15:0] pos,
                            bit drain);
      cmd_entry_type e;
      int p;
      p = int'($signed(pos));
      e.item.action   = act;
      e.item.value    = val;
      e.item.position = pos;
      e.drain_first   = drain;
      cmd_queue.push_back(e);
      case (act)
         ple_pkg::ACT_APPEND: begin
            if (gen_len < ple_pkg::CAPACITY) gen_len++;
         end
         ple_pkg::ACT_INSERT: begin
            if (p >= 0 && p <= gen_len && gen_len < ple_pkg::CAPACITY) gen_len++;
         end
         ple_pkg::ACT_DELETE: begin
            if (p >= 1 && p <= gen_len) gen_len--;
         end
         default: ;
      endcase
   endtask

   function automatic void forecast_listing(ple_pkg::req_item_type it);
      int                                p;
      int                                n;
      ple_pkg::error_type                err;
      ple_pkg::rsp_item_type             r;
      logic signed [ple_pkg::DATA_W-1:0] t;
      p   = int'($signed(it.position));
      err = ple_pkg::ERR_NONE;
      case (ple_pkg::action_type'(it.action))
         ple_pkg::ACT_APPEND: begin
            if (shadow_list.size() >= ple_pkg::CAPACITY) err = ple_pkg::ERR_FULL;
            else shadow_list.push_back(it.value);
         end
         ple_pkg::ACT_INSERT: begin
            if (p < 0 || p > shadow_list.size()) err = ple_pkg::ERR_RANGE;
            else if (shadow_list.size() >= ple_pkg::CAPACITY) err = ple_pkg::ERR_FULL;
            else shadow_list.insert(p, it.value);
         end
         ple_pkg::ACT_DELETE: begin
            if (p < 1 || p > shadow_list.size()) err = ple_pkg::ERR_RANGE;
            else shadow_list.delete(p - 1);
         end
         default: begin
            n = shadow_list.size();
            for (int i = 0; i < n / 2; i++) begin
               t                      = shadow_list[i];
               shadow_list[i]         = shadow_list[n - 1 - i];
               shadow_list[n - 1 - i] = t;
            end
         end
      endcase
      n = shadow_list.size();
      if (n == 0) begin
         r.element    = '0;
         r.list_empty = 1'b1;
         r.error_code = err;
         r.last       = 1'b1;
         listing_queue.push_back(r);
      end else begin
         for (int i = 0; i < n; i++) begin
            r.element    = shadow_list[i];
            r.list_empty = 1'b0;
            r.error_code = err;
            r.last       = (i == n - 1);
            listing_queue.push_back(r);
         end
      end
   endfunction

   // Driver: present a new item at the falling edge once the previous one is taken.
   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (accepted_count < 90) ? 17 : (accepted_count < 180) ? 80 : 0;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !item_taken) begin
         // hold until accepted
      end else if (cmd_queue.size() == 0) begin
         start <= 1'b0;
      end else if (cmd_queue[0].drain_first && listing_queue.size() != 0) begin
         start <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
      end else begin
         req_item <= cmd_queue[0].item;
         start    <= 1'b1;
         cmd_queue.pop_front();
      end
   end

   // Monitor: check results and predict on each accepted item.
   always @(posedge clock) begin
      ple_pkg::rsp_item_type want;
      if (reset) begin
         item_taken <= 1'b0;
      end else begin
         item_taken <= start && !busy;
         if (rsp_strobe) begin
            if (listing_queue.size() == 0) begin
               report_mismatch("unexpected result, element", rsp_item.element, '0);
            end else begin
               want = listing_queue.pop_front();
               if (rsp_item.element !== want.element)
                  report_mismatch("element", rsp_item.element, want.element);
               if (rsp_item.list_empty !== want.list_empty)
                  report_mismatch("list_empty", 32'(rsp_item.list_empty),
                                  32'(want.list_empty));
               if (rsp_item.error_code !== want.error_code)
                  report_mismatch("error_code", 32'(rsp_item.error_code),
                                  32'(want.error_code));
               if (rsp_item.last !== want.last)
                  report_mismatch("last", 32'(rsp_item.last), 32'(want.last));
            end
            result_count++;
         end
         if (start && !busy) begin
            forecast_listing(req_item);
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d idle cycles", quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int roll;
      bit drain;
      bit growing;
      int full_hits;

      // Directed: empty list corners, value extremes, every bad index form.
      queue_cmd(ple_pkg::ACT_REVERSE, 32'hDEAD_BEEF, 16'h7FFF, 1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'd1,    1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h1,         16'd1,    1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h7FFF_FFFF, 16'd0,    1'b0);
      queue_cmd(ple_pkg::ACT_REVERSE, 32'h0,         16'h0,    1'b0);
      queue_cmd(ple_pkg::ACT_APPEND,  32'h8000_0000, 16'h8000, 1'b0);
      queue_cmd(ple_pkg::ACT_APPEND,  32'h0000_0000, 16'hFFFF, 1'b0);
      queue_cmd(ple_pkg::ACT_APPEND,  32'hFFFF_FFFF, 16'h0,    1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h1234_5678, 16'(gen_len), 1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h5A5A_A5A5, 16'd2,    1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h1111_1111, 16'hFFFF, 1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h2222_2222, 16'h8000, 1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h3333_3333, 16'h7FFF, 1'b0);
      queue_cmd(ple_pkg::ACT_INSERT,  32'h4444_4444, 16'(gen_len + 1), 1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'd0,    1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'h8000, 1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'(gen_len + 1), 1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'h7FFF, 1'b0);
      queue_cmd(ple_pkg::ACT_REVERSE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'd1,    1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'(gen_len), 1'b0);
      queue_cmd(ple_pkg::ACT_DELETE,  32'h0,         16'd2,    1'b0);
      while (gen_len > 0) queue_cmd(ple_pkg::ACT_DELETE, 32'h0, 16'd1, 1'b0);

      // Random: fill to the brim, hit the full error a few times, drain to empty.
      growing   = 1'b1;
      full_hits = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll  = $urandom_range(0, 99);
         drain = (n == 0) || ($urandom_range(0, 49) == 0);
         if (roll < 10) begin
            queue_cmd(2'($urandom_range(0, 3)), $urandom, 16'($urandom), drain);
         end else if (roll < 18) begin
            queue_cmd(ple_pkg::ACT_REVERSE, $urandom, 16'($urandom), drain);
         end else if (growing) begin
            if (gen_len == ple_pkg::CAPACITY) full_hits++;
            if (roll < 59) begin
               queue_cmd(ple_pkg::ACT_APPEND, $urandom, 16'($urandom), drain);
            end else begin
               queue_cmd(ple_pkg::ACT_INSERT, $urandom, 16'($urandom_range(0, gen_len)),
                         drain);
            end
         end else if (gen_len > 0) begin
            queue_cmd(ple_pkg::ACT_DELETE, $urandom, 16'($urandom_range(1, gen_len)), drain);
         end else begin
            queue_cmd(ple_pkg::ACT_DELETE, $urandom, 16'($urandom), drain);
         end
         if (growing && full_hits >= 3) begin
            growing   = 1'b0;
            full_hits = 0;
         end else if (!growing && gen_len == 0) begin
            growing = 1'b1;
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (cmd_queue.size() != 0 || start) @(posedge clock);
      while (listing_queue.size() != 0) @(posedge clock);
      // let any stray result show up
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
